// ----- src/fcrs_pkg.sv -----
// Shared types and constants for the factor clock rate selector.
// No dependencies; imported by every module of the block.
package fcrs_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned MUL_W    = 16;
    localparam int unsigned DIV_W    = 16;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned PROD_W   = RATE_W + MUL_W;
    localparam int unsigned SHIFT_W  = 5;
    localparam int unsigned WIDTH_W  = 4;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned MASK_W   = 16;

    // Command modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SELECT = 2'd1;
    localparam logic [1:0] MODE_RECALC = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH = 1'd1;

    localparam logic [WIDTH_W-1:0] FIELD_WIDTH_RESET = 4'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [3:0]        entry_index;
        logic [CODE_W-1:0] entry_code;
        logic [MUL_W-1:0]  entry_mul;
        logic [DIV_W-1:0]  entry_div;
        logic [RATE_W-1:0] src_rate;
        logic [RATE_W-1:0] target_rate;
        logic [RATE_W-1:0] control_word;
    } t_cmd;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] new_control_word;
        logic              found;
    } t_res;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [MUL_W-1:0]  mul;
        logic [DIV_W-1:0]  div;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] parent;
        logic [MUL_W-1:0]  mul;
        logic [DIV_W-1:0]  div;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- src/fcrs_table.sv -----
// Factor table: code, multiplier and divisor per slot, one write and one read port.
// Depends on fcrs_pkg. Slots never written read back as zero (empty table).
module fcrs_table #(
    parameter int unsigned TABLE_DEPTH = fcrs_pkg::DEFAULT_TABLE_DEPTH,
    parameter int unsigned IDX_W       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  fcrs_pkg::t_entry     i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output fcrs_pkg::t_entry     o_rdata
);
    import fcrs_pkg::*;

    t_entry                 r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_comb begin
        o_rdata = '0;
        if (32'(i_raddr) < TABLE_DEPTH) begin
            if (r_valid[i_raddr]) begin
                o_rdata = r_mem[i_raddr];
            end
        end
    end

endmodule

// ----- src/fcrs_div.sv -----
// Shared rate unit: registers parent*mul, then a restoring divide by div, one bit a cycle.
// Depends on fcrs_pkg. Quotient equals floor(parent*mul/div).
module fcrs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcrs_pkg::t_div_req   i_req,
    output fcrs_pkg::t_div_rsp   o_rsp
);
    import fcrs_pkg::*;

    localparam int unsigned STEP_W = $clog2(PROD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [PROD_W-1:0] r_num,  n_num;
    logic [DIV_W-1:0]  r_rem,  n_rem;
    logic [DIV_W-1:0]  r_den,  n_den;
    logic [DIV_W:0]    rem_sh;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_num[PROD_W-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_num  = i_req.parent * i_req.mul;
            n_rem  = '0;
            n_den  = i_req.div;
        end else if (r_busy) begin
            n_rem  = ge ? DIV_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_W-1:0];
            n_num  = {r_num[PROD_W-2:0], ge};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still stepping");
`endif

endmodule

// ----- src/factor_clock_rate_select_core.sv -----
// Top level of the factor clock rate selector: sequencer, config registers, result.
// Depends on fcrs_pkg, fcrs_table and fcrs_div.
//
//  channel   | handshake            | payload      | direction
//  ----------+----------------------+--------------+----------
//  command   | start, busy          | i_cmd        | in
//  result    | o_strobe (no stall)  | o_res        | out
//  config    | i_cfg_we             | i_cfg_idx,   | in
//            |                      | i_cfg_data   |
//
// A beat is taken when start is high and busy is low; busy stays high until
// the result beat has been shown. Load and unused modes strobe in the cycle
// right after the accept edge. Select walks the entries in order: for each, a
// fetch starts the divider, which loads the product, runs its divide steps
// and raises done. Recalc skips non-matching entries in the fetch state and
// strobes in the cycle after the divide of its match. Reset is synchronous and
// empties the table. o_strobe is high for exactly one cycle per result beat;
// the receiver cannot stall it.
module factor_clock_rate_select_core #(
    parameter int unsigned TABLE_DEPTH = fcrs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fcrs_pkg::t_cmd                    i_cmd,
    output logic                              o_strobe,
    output fcrs_pkg::t_res                    o_res,
    input  logic                              i_cfg_we,
    input  logic [fcrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fcrs_pkg::CFG_W-1:0]        i_cfg_data
);
    import fcrs_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;

    // config
    logic [SHIFT_W-1:0] r_field_shift;
    logic [WIDTH_W-1:0] r_field_width;

    // captured command and working registers
    logic [1:0]        r_mode,      n_mode;
    logic [RATE_W-1:0] r_parent,    n_parent;
    logic [RATE_W-1:0] r_target,    n_target;
    logic [RATE_W-1:0] r_ctrl,      n_ctrl;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    logic [RATE_W-1:0] r_best,      n_best;
    logic [CODE_W-1:0] r_best_code, n_best_code;
    logic [RATE_W-1:0] r_rate,      n_rate;
    logic [RATE_W-1:0] r_word,      n_word;
    logic              r_found,     n_found;

    logic       accept;
    logic       walk_end;
    logic       code_match;
    logic       qualifies;
    logic       tbl_we;
    t_entry     tbl_wdata;
    t_entry     rd;
    t_div_req   div_req;
    t_div_rsp   div_rsp;

    logic [MASK_W-1:0] mask16;
    logic [RATE_W-1:0] mask32;
    logic [RATE_W-1:0] field_val;
    logic [RATE_W-1:0] code32;
    logic [RATE_W-1:0] sat_rate;

    assign accept = start && !busy;

    fcrs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (IDX_W'(i_cmd.entry_index)),
        .i_wdata (tbl_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd)
    );

    fcrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // table writes happen straight off the command beat
    assign tbl_we = accept && (i_cmd.mode == MODE_LOAD)
                    && (32'(i_cmd.entry_index) < TABLE_DEPTH);
    assign tbl_wdata.code = i_cmd.entry_code;
    assign tbl_wdata.mul  = i_cmd.entry_mul;
    assign tbl_wdata.div  = i_cmd.entry_div;

    // factor field helpers
    assign mask16    = MASK_W'((17'd1 << r_field_width) - 17'd1);
    assign mask32    = 32'(mask16) << r_field_shift;
    assign field_val = (r_ctrl >> r_field_shift) & 32'(mask16);
    assign code32    = 32'(r_best_code & mask16[CODE_W-1:0]) << r_field_shift;

    // walk stops at a zero divisor (as in an empty slot) or past the last slot
    assign walk_end   = (r_cnt == CNT_W'(TABLE_DEPTH)) || (rd.div == '0);
    assign code_match = (32'(rd.code) == field_val);
    // larger than best also rules out a zero candidate
    assign qualifies  = (div_rsp.quot <= PROD_W'(r_target))
                        && (div_rsp.quot > PROD_W'(r_best));
    assign sat_rate   = (|div_rsp.quot[PROD_W-1:RATE_W]) ? '1 : div_rsp.quot[RATE_W-1:0];

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_shift <= '0;
            r_field_width <= FIELD_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIELD_SHIFT: r_field_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_FIELD_WIDTH: r_field_width <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.mode == MODE_SELECT || i_cmd.mode == MODE_RECALC) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: begin
                if (walk_end) begin
                    n_state = S_DONE;
                end else if (r_mode == MODE_RECALC && !code_match) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = (r_mode == MODE_RECALC) ? S_DONE : S_FETCH;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mode      = r_mode;
        n_parent    = r_parent;
        n_target    = r_target;
        n_ctrl      = r_ctrl;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_best_code = r_best_code;
        n_rate      = r_rate;
        n_word      = r_word;
        n_found     = r_found;
        div_req.start  = 1'b0;
        div_req.parent = r_parent;
        div_req.mul    = rd.mul;
        div_req.div    = rd.div;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode      = i_cmd.mode;
                    n_parent    = i_cmd.src_rate;
                    n_target    = i_cmd.target_rate;
                    n_ctrl      = i_cmd.control_word;
                    n_cnt       = '0;
                    n_best      = '0;
                    n_best_code = '0;
                    n_rate      = '0;
                    n_word      = '0;
                    n_found     = 1'b0;
                end
            end
            S_FETCH: begin
                if (walk_end) begin
                    if (r_mode == MODE_SELECT && r_best != '0) begin
                        n_rate  = r_best;
                        n_word  = (r_ctrl & ~mask32) | code32;
                        n_found = 1'b1;
                    end else begin
                        n_rate  = '0;
                        n_word  = r_ctrl;
                        n_found = 1'b0;
                    end
                end else if (r_mode == MODE_RECALC && !code_match) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    div_req.start = 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_mode == MODE_RECALC) begin
                        n_rate  = sat_rate;
                        n_word  = r_ctrl;
                        n_found = 1'b1;
                    end else begin
                        if (qualifies) begin
                            n_best      = div_rsp.quot[RATE_W-1:0];
                            n_best_code = rd.code;
                        end
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_parent    <= n_parent;
        r_target    <= n_target;
        r_ctrl      <= n_ctrl;
        r_best      <= n_best;
        r_best_code <= n_best_code;
        r_rate      <= n_rate;
        r_word      <= n_word;
        r_found     <= n_found;
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_strobe               = (r_state == S_DONE);
    assign o_res.rate             = r_rate;
    assign o_res.new_control_word = r_word;
    assign o_res.found            = r_found;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command beat taken but block not busy");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result beat not a single cycle");
    // a recalc match may carry a zero rate; a select hit never does
    a_found_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.found && r_mode == MODE_SELECT) |-> (o_res.rate != '0))
        else $error("found flagged with zero rate");
    a_div_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside divide wait");
`endif

endmodule

// ----- sim/factor_clock_rate_select_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for factor_clock_rate_select_core: directed table, then random beats.
// Depends on fcrs_pkg and the block RTL; expected results are predicted locally or typed in.
module factor_clock_rate_select_core_tb;
    import fcrs_pkg::*;

    localparam int unsigned DEPTH          = DEFAULT_TABLE_DEPTH;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;   // unused mode, block returns all zero
    localparam int unsigned N_PHASES       = 9;
    localparam int unsigned BEATS_PER_PHASE = 66;
    // Covers the worst select, which walks all 16 entries, plus the longest sender gap.
    localparam int unsigned STALL_LIMIT    = 8000;
    localparam int unsigned SETTLE_CYCLES  = 8;

    typedef struct packed {
        t_cmd cmd;
        logic typed;   // expected result typed in rather than predicted
        t_res res;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_cmd                 cmd_beat = '0;
    logic                 o_strobe;
    t_res                 o_res;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_FIELD_SHIFT;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Local copy of the factor table (advanced at each accepted beat) and of the field registers.
    logic [CODE_W-1:0]    tbl_code [DEPTH];
    logic [MUL_W-1:0]     tbl_mul  [DEPTH];
    logic [DIV_W-1:0]     tbl_div  [DEPTH];
    logic [SHIFT_W-1:0]   fld_shift = '0;
    logic [WIDTH_W-1:0]   fld_width = FIELD_WIDTH_RESET;

    t_res                 rate_result_q [$];
    t_dir_row             dir_rows [$];
    int unsigned          mismatch_count = 0;
    int unsigned          stall_cycles = 0;
    int unsigned          burst_left = 1;

    factor_clock_rate_select_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (cmd_beat),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Rate predictor
    // ------------------------------------------------------------------

    // Exact p*m/d without a wide product: whole part plus scaled remainder.
    function automatic logic [63:0] scaled_rate(input logic [63:0] p, input logic [63:0] m,
                                                input logic [63:0] d);
        return (p / d) * m + ((p % d) * m) / d;
    endfunction

    function automatic logic [63:0] field_mask();
        return (64'd1 << fld_width) - 64'd1;
    endfunction

    // Number of entries a walk visits: up to the first zero divisor.
    function automatic int unsigned table_len();
        int unsigned n;
        n = 0;
        while (n < DEPTH && tbl_div[n] != '0)
            n++;
        return n;
    endfunction

    function automatic t_res predict_rate_result(input t_cmd c);
        t_res        res;
        logic [63:0] best, cand, mask, code_bits, field, word;
        int unsigned best_i;
        bit          hit;
        res = '0;
        best = '0;
        best_i = 0;
        hit = 1'b0;
        case (c.mode)
            MODE_LOAD: begin
                // entry_index cannot exceed the 16-deep table, so every load lands
                tbl_code[c.entry_index] = c.entry_code;
                tbl_mul[c.entry_index]  = c.entry_mul;
                tbl_div[c.entry_index]  = c.entry_div;
            end
            MODE_SELECT: begin
                for (int i = 0; i < DEPTH && tbl_div[i] != '0; i++) begin
                    cand = scaled_rate(c.src_rate, tbl_mul[i], tbl_div[i]);
                    // strict > keeps the first entry on ties; zero never qualifies
                    if (cand <= c.target_rate && cand > best) begin
                        best = cand;
                        best_i = i;
                    end
                end
                res.new_control_word = c.control_word;
                if (best != '0) begin
                    mask = field_mask() << fld_shift;
                    code_bits = ({56'd0, tbl_code[best_i]} & field_mask()) << fld_shift;
                    word = ({32'd0, c.control_word} & ~mask) | code_bits;
                    res.new_control_word = word[31:0];
                    res.rate = best[31:0];
                    res.found = 1'b1;
                end
            end
            MODE_RECALC: begin
                field = ({32'd0, c.control_word} >> fld_shift) & field_mask();
                res.new_control_word = c.control_word;
                for (int i = 0; i < DEPTH && tbl_div[i] != '0 && !hit; i++) begin
                    // stored code compared unmasked
                    if ({56'd0, tbl_code[i]} == field) begin
                        cand = scaled_rate(c.src_rate, tbl_mul[i], tbl_div[i]);
                        res.rate = (cand > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cand[31:0];
                        res.found = 1'b1;
                        hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_cmd mk_cmd(input logic [1:0] mode, input logic [3:0] idx,
                                    input logic [7:0] code, input logic [15:0] mul,
                                    input logic [15:0] div, input logic [31:0] parent,
                                    input logic [31:0] target, input logic [31:0] ctrl);
        t_cmd c;
        c.mode = mode;
        c.entry_index = idx;
        c.entry_code = code;
        c.entry_mul = mul;
        c.entry_div = div;
        c.src_rate = parent;
        c.target_rate = target;
        c.control_word = ctrl;
        return c;
    endfunction

    function automatic t_res mk_res(input logic [31:0] rate, input logic [31:0] word,
                                    input logic found);
        t_res r;
        r.rate = rate;
        r.new_control_word = word;
        r.found = found;
        return r;
    endfunction

    function automatic void add_row(input t_cmd c, input logic typed, input t_res r);
        t_dir_row row;
        row.cmd = c;
        row.typed = typed;
        row.res = r;
        dir_rows.push_back(row);
    endfunction

    // Random beat shaped so selects land near a real candidate and recalcs carry a
    // stored code in the field; loads mostly land in or just past the walked part of the table.
    function automatic t_cmd random_cmd();
        t_cmd        c;
        int unsigned n, k, pick;
        logic [63:0] cand, mask, word;
        n = table_len();
        mask = field_mask();
        c.src_rate = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom;
        c.target_rate = $urandom;
        c.control_word = $urandom;
        c.entry_index = 4'($urandom_range(0, 15));
        c.entry_code = 8'($urandom_range(0, 255));
        c.entry_mul = 16'($urandom_range(0, 65535));
        c.entry_div = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (n == 0 && pick >= 30 && pick < 80)
            pick = 0;
        if (pick < 30) begin
            c.mode = MODE_LOAD;
            if ($urandom_range(0, 9) < 6)
                c.entry_index = 4'($urandom_range(0, (n < DEPTH) ? n : DEPTH - 1));
            if ($urandom_range(0, 9) < 6)
                c.entry_code = c.entry_code & mask[7:0];
            case ($urandom_range(0, 9))
                0:       c.entry_mul = '0;
                1:       c.entry_mul = 16'hFFFF;
                2, 3, 4: c.entry_mul = 16'($urandom_range(1, 16));
                default: ;
            endcase
            case ($urandom_range(0, 24))
                0, 1:       c.entry_div = '0;      // cuts the table
                2:          c.entry_div = 16'hFFFF;
                3, 4, 5, 6: c.entry_div = 16'($urandom_range(1, 16));
                default:    c.entry_div = 16'($urandom_range(1, 65535));
            endcase
        end else if (pick < 62) begin
            c.mode = MODE_SELECT;
            if (n != 0 && $urandom_range(0, 99) < 65) begin
                k = $urandom_range(0, n - 1);
                cand = scaled_rate(c.src_rate, tbl_mul[k], tbl_div[k]);
                if (cand <= 64'hFFFF_FFFE) begin
                    case ($urandom_range(0, 2))
                        0:       c.target_rate = cand[31:0];
                        1:       c.target_rate = cand[31:0] + 32'd1;
                        default: c.target_rate = (cand == '0) ? '0 : cand[31:0] - 32'd1;
                    endcase
                end
            end
        end else if (pick < 95) begin
            c.mode = MODE_RECALC;
            if (n != 0 && $urandom_range(0, 99) < 75) begin
                k = $urandom_range(0, n - 1);
                word = ({32'd0, c.control_word} & ~(mask << fld_shift))
                     | (({56'd0, tbl_code[k]} & mask) << fld_shift);
                c.control_word = word[31:0];
            end
        end else begin
            c.mode = MODE_SPARE;
        end
        return c;
    endfunction

    // Present one command beat, wait for it to be taken, queue its expected result.
    // start stays high across a burst; it drops when the burst runs out or when results are drained.
    task automatic send_beat(input t_cmd c, input logic typed, input t_res typed_res);
        t_res r;
        start <= 1'b1;
        cmd_beat <= c;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        r = predict_rate_result(c);
        rate_result_q.push_back(typed ? typed_res : r);
        burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            // one burst in ten runs long, with gaps only where results are drained
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            repeat ($urandom_range(1, 25))
                @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding result; block is idle afterward.
    task automatic drain_results();
        if (start) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (rate_result_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    // Write both field registers on consecutive edges; only called while idle.
    task automatic set_field(input logic [4:0] shift, input logic [CFG_W-1:0] width_data);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_FIELD_SHIFT;
        cfg_data <= shift;
        @(posedge i_clk);
        fld_shift = shift;
        cfg_idx <= CFG_FIELD_WIDTH;
        cfg_data <= width_data;
        @(posedge i_clk);
        fld_width = width_data[WIDTH_W-1:0];   // upper data bit is not stored
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checking: strobe marks a one-cycle result beat, no back-pressure.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (rate_result_q.size() == 0) begin
                $error("result beat with nothing outstanding: %h", o_res);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = rate_result_q.pop_front();
                if (o_res.rate !== want.rate) begin
                    $error("rate: expected %h, got %h", want.rate, o_res.rate);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.new_control_word !== want.new_control_word) begin
                    $error("new_control_word: expected %h, got %h",
                           want.new_control_word, o_res.new_control_word);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_res.found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, o_res.found);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: any command or result beat restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_res        no_res;
        logic [4:0]  shift_sel [5];
        logic [4:0]  width_sel [5];
        no_res = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_code[i] = '0;
            tbl_mul[i] = '0;
            tbl_div[i] = '0;
        end
        // Phase settings: far ends of shift, width 8, 1, empty field, widest mask,
        // and a width write with the unused data bit set.
        shift_sel = '{5'd31, 5'd0, 5'd28, 5'd17, 5'd5};
        width_sel = '{5'd8, 5'd1, 5'd0, 5'd15, 5'b11001};

        // Directed part, reset field settings (shift 0, width 4).
        // Empty table: select and recalc find nothing; spare mode and loads give zeros.
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hDEAD_BEEF), 1'b1, mk_res(32'd0, 32'hDEAD_BEEF, 1'b0));
        add_row(mk_cmd(MODE_RECALC, 4'd0, 8'h00, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0, 32'h0),
                1'b1, no_res);
        add_row(mk_cmd(MODE_SPARE, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, no_res);
        add_row(mk_cmd(MODE_LOAD, 4'd0, 8'h03, 16'd1, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF), 1'b1, no_res);
        // code wider than the 4-bit field, so recalc can never match it
        add_row(mk_cmd(MODE_LOAD, 4'd1, 8'hFF, 16'hFFFF, 16'd1, 32'h0, 32'h0, 32'h0),
                1'b1, no_res);
        add_row(mk_cmd(MODE_LOAD, 4'd2, 8'h05, 16'd3, 16'd4, 32'h0, 32'h0, 32'h0), 1'b1, no_res);
        // same ratio as slot 0: a select tie goes to slot 0
        add_row(mk_cmd(MODE_LOAD, 4'd3, 8'h07, 16'd1, 16'd2, 32'h0, 32'h0, 32'h0), 1'b1, no_res);
        add_row(mk_cmd(MODE_LOAD, 4'd4, 8'h06, 16'hFFFF, 16'd1, 32'h0, 32'h0, 32'h0),
                1'b1, no_res);
        // zero multiplier: candidate of zero never qualifies
        add_row(mk_cmd(MODE_LOAD, 4'd5, 8'h00, 16'd0, 16'd1, 32'h0, 32'h0, 32'h0), 1'b1, no_res);
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'd1000, 32'd600,
                       32'hFFFF_FFFF), 1'b0, no_res);
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'd0, 32'hFFFF_FFFF,
                       32'h1234_5678), 1'b1, mk_res(32'd0, 32'h1234_5678, 1'b0));
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'd1000, 32'd0, 32'h0),
                1'b1, no_res);
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'h0), 1'b0, no_res);
        add_row(mk_cmd(MODE_RECALC, 4'd0, 8'h00, 16'h0, 16'h0, 32'd1000, 32'h0,
                       32'hABCD_0003), 1'b0, no_res);
        add_row(mk_cmd(MODE_RECALC, 4'd0, 8'h00, 16'h0, 16'h0, 32'd1000, 32'h0, 32'h0000_000F),
                1'b1, mk_res(32'd0, 32'h0000_000F, 1'b0));
        // slot 4 multiplies the full parent rate by 0xFFFF: saturates
        add_row(mk_cmd(MODE_RECALC, 4'd0, 8'h00, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0,
                       32'hFFFF_FFF6), 1'b1, mk_res(32'hFFFF_FFFF, 32'hFFFF_FFF6, 1'b1));
        // matches slot 5: found with a zero rate
        add_row(mk_cmd(MODE_RECALC, 4'd0, 8'h00, 16'h0, 16'h0, 32'd1000, 32'h0, 32'h0),
                1'b0, no_res);
        // slot 15 lies past the end marker and is never walked
        add_row(mk_cmd(MODE_LOAD, 4'd15, 8'hAA, 16'd7, 16'hFFFF, 32'h0, 32'h0, 32'h0),
                1'b1, no_res);
        add_row(mk_cmd(MODE_LOAD, 4'd2, 8'h05, 16'd3, 16'd0, 32'h0, 32'h0, 32'h0), 1'b1, no_res);
        add_row(mk_cmd(MODE_SELECT, 4'd0, 8'h00, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                       32'h5555_AAAA), 1'b0, no_res);
        add_row(mk_cmd(MODE_LOAD, 4'd2, 8'h05, 16'd3, 16'd4, 32'h0, 32'h0, 32'h0), 1'b1, no_res);

        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
        drain_results();

        // Random part: one field setting per phase, registers written only while idle.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 5)
                set_field(shift_sel[ph], width_sel[ph]);
            else
                set_field(5'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)));
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                send_beat(random_cmd(), 1'b0, no_res);
                // now and then hold off until the block has answered everything
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (20)
            @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
